@@ hw/rtl/urs_pkg.sv @@
// Shared types and constants for the ultrasonic range sequencer.
`timescale 1ns / 1ps

package urs_pkg;

  // Register field widths
  localparam int TrigW   = 10;
  localparam int ListenW = 16;
  localparam int IdleW   = 19;
  localparam int TpcW    = 8;
  localparam int DistW   = 11;
  localparam int SensorW = 2;
  localparam int TrigLnW = 3;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 19;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegTrigger = 3'd0;
  localparam logic [CfgIdxW-1:0] RegListen  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegIdle    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTpc     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxDist = 3'd4;

  // Register reset values
  localparam logic [TrigW-1:0]   TrigReset   = 10'd10;
  localparam logic [ListenW-1:0] ListenReset = 16'd50000;
  localparam logic [IdleW-1:0]   IdleReset   = 19'd350000;
  localparam logic [TpcW-1:0]    TpcReset    = 8'd58;
  localparam logic [DistW-1:0]   MaxDistReset = 11'd400;

  // Saturation limit of the centimeter counter
  localparam logic [DistW-1:0] CmMax = 11'd2047;

  typedef struct packed {
    logic [TrigW-1:0]   trigger_ticks;
    logic [ListenW-1:0] listen_ticks;
    logic [IdleW-1:0]   idle_ticks;
    logic [TpcW-1:0]    ticks_per_cm;
    logic [DistW-1:0]   max_distance;
  } cfg_t;

  typedef struct packed {
    logic [TrigLnW-1:0] trigger_lines;
    logic               report_valid;
    logic [SensorW-1:0] sensor_number;
    logic [DistW-1:0]   distance_cm;
    logic               last_of_round;
  } res_t;

endpackage

@@ hw/rtl/urs_core.sv @@
// Per-tick sequencer state and result logic for the range sequencer.
`timescale 1ns / 1ps

module urs_core #(
  parameter int SENSOR_COUNT = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          echo_i,
  input  urs_pkg::cfg_t cfg_i,
  output urs_pkg::res_t res_o
);
  import urs_pkg::*;

  localparam logic [1:0] PhTrigger = 2'd0;
  localparam logic [1:0] PhListen  = 2'd1;
  localparam logic [1:0] PhIdle    = 2'd2;

  logic [1:0]         phase_q, phase_d;
  logic [SensorW-1:0] sensor_q, sensor_d;
  logic [IdleW-1:0]   ticks_q, ticks_d;
  logic [TpcW-1:0]    sub_q, sub_d;
  logic [DistW-1:0]   run_q, run_d;
  logic [DistW-1:0]   latched_q, latched_d;
  logic               echo_prev_q;

  logic               is_last;
  logic [TpcW-1:0]    sub_inc;
  logic [IdleW-1:0]   ticks_inc;
  logic               measuring;

  assign is_last   = ({1'b0, sensor_q} + 3'd1) >= 3'(SENSOR_COUNT);
  assign sub_inc   = sub_q + 8'd1;
  assign ticks_inc = ticks_q + 19'd1;
  assign measuring = (phase_q == PhTrigger) || (phase_q == PhListen);

  // Next state and result for the current tick
  always_comb begin
    phase_d   = phase_q;
    sensor_d  = sensor_q;
    ticks_d   = ticks_inc;
    sub_d     = sub_q;
    run_d     = run_q;
    latched_d = latched_q;
    res_o     = '0;

    if (phase_q == PhTrigger) begin
      res_o.trigger_lines = TrigLnW'(3'b001 << sensor_q);
    end

    // Echo accumulation and falling-edge latch
    if (measuring) begin
      if (echo_i) begin
        sub_d = sub_inc;
        if (sub_inc >= cfg_i.ticks_per_cm || sub_inc == '0) begin
          sub_d = '0;
          if (run_q < CmMax) begin
            run_d = run_q + 11'd1;
          end
        end
      end
      if (echo_prev_q && !echo_i) begin
        latched_d = run_d;
      end
    end

    unique case (phase_q)
      PhTrigger: begin
        if (ticks_inc >= IdleW'(cfg_i.trigger_ticks)) begin
          phase_d = PhListen;
          ticks_d = '0;
        end
      end
      PhListen: begin
        if (ticks_inc >= IdleW'(cfg_i.listen_ticks)) begin
          res_o.report_valid  = 1'b1;
          res_o.sensor_number = sensor_q;
          res_o.last_of_round = is_last;
          res_o.distance_cm   = (latched_d != '0 && latched_d < cfg_i.max_distance) ?
                                latched_d : '0;
          ticks_d = '0;
          if (!is_last || cfg_i.idle_ticks == '0) begin
            phase_d   = PhTrigger;
            sensor_d  = is_last ? '0 : sensor_q + 2'd1;
            sub_d     = '0;
            run_d     = '0;
            latched_d = '0;
          end else begin
            phase_d = PhIdle;
          end
        end
      end
      PhIdle: begin
        if (ticks_inc >= cfg_i.idle_ticks) begin
          phase_d   = PhTrigger;
          sensor_d  = '0;
          ticks_d   = '0;
          sub_d     = '0;
          run_d     = '0;
          latched_d = '0;
        end
      end
      default: begin
        phase_d = PhTrigger;
        ticks_d = '0;
      end
    endcase
  end

  // State registers, advanced once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhTrigger;
      sensor_q    <= '0;
      ticks_q     <= '0;
      sub_q       <= '0;
      run_q       <= '0;
      latched_q   <= '0;
      echo_prev_q <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      sensor_q    <= sensor_d;
      ticks_q     <= ticks_d;
      sub_q       <= sub_d;
      run_q       <= run_d;
      latched_q   <= latched_d;
      echo_prev_q <= echo_i;
    end
  end

endmodule

@@ hw/rtl/ultrasonic_range_sequencer.sv @@
// The result of an accepted tick request is registered in the output register or,
// if that still waits, in the skid stage. Throughput: one tick request per clock
// while the skid stage is empty, so the input stays open while one result waits.
// Reset (rst_ni low, asynchronous): registers return to their defaults, the
// sequencer restarts in the trigger phase of sensor 0 and the output is empty.
`timescale 1ns / 1ps

module ultrasonic_range_sequencer #(
  parameter int SENSOR_COUNT = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Tick input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] echo_level, [7:1] zero
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] trigger_lines, [4:3] sensor_number,
                                      // [15:5] distance_cm
  output logic        m_axis_tuser,   // [0] report_valid
  output logic        m_axis_tlast,   // last_of_round
  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [urs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [urs_pkg::CfgDataW-1:0]    cfg_data_i
);
  import urs_pkg::*;

  cfg_t cfg_q;
  res_t res;
  res_t out_q, out_d, skid_q, skid_d;
  logic out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic in_fire, out_fire;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks <= TrigReset;
      cfg_q.listen_ticks  <= ListenReset;
      cfg_q.idle_ticks    <= IdleReset;
      cfg_q.ticks_per_cm  <= TpcReset;
      cfg_q.max_distance  <= MaxDistReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegTrigger: cfg_q.trigger_ticks <= cfg_data_i[TrigW-1:0];
        RegListen:  cfg_q.listen_ticks  <= cfg_data_i[ListenW-1:0];
        RegIdle:    cfg_q.idle_ticks    <= cfg_data_i[IdleW-1:0];
        RegTpc:     cfg_q.ticks_per_cm  <= cfg_data_i[TpcW-1:0];
        RegMaxDist: cfg_q.max_distance  <= cfg_data_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;

  urs_core #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .echo_i (s_axis_tdata[0]),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Output register with skid stage
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.distance_cm, out_q.sensor_number, out_q.trigger_lines};
  assign m_axis_tuser  = out_q.report_valid;
  assign m_axis_tlast  = out_q.last_of_round;

  // Skid stage only fills behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while output register is empty");

  // At most one trigger line is driven
  a_trig_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[2:0]))
    else $error("more than one trigger line driven");

  // A report never coincides with a trigger drive
  a_report_no_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[2:0] == 3'd0))
    else $error("report issued during trigger phase");

  // Without a report the reading fields are zero
  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[15:3] == '0 && !m_axis_tlast))
    else $error("reading fields set without a report");

endmodule

@@ bench/ultrasonic_range_sequencer_tb.sv @@
// Self-checking bench for the ultrasonic range sequencer: directed table, then random pulse trains.
`timescale 1ns / 1ps

module ultrasonic_range_sequencer_tb;
  import urs_pkg::*;

  localparam int SensorCount = 3;
  localparam int Limit       = 500000;
  localparam int DrainPad    = 4;
  localparam int RandPhases  = 10;
  localparam int PhaseTicks  = 50;
  // First index past the register list; writes there must be ignored
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd5;

  typedef enum logic [1:0] {PhTrigger, PhListen, PhIdle} seq_phase_e;
  typedef enum logic {RowTick, RowWrite} row_kind_e;

  // One tick request with an optional hand-typed result
  typedef struct packed {
    logic echo;
    logic pinned;
    res_t pin;
  } tick_req_t;

  typedef struct packed {
    row_kind_e             kind;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   data;
    logic                  echo;
    logic [15:0]           reps;
    logic                  pinned;
    res_t                  pin;
  } dir_row_t;

  localparam res_t NoPin          = '0;
  localparam res_t PinSensor0     = '{3'b001, 1'b0, 2'd0, 11'd0, 1'b0};
  localparam res_t PinSensor1     = '{3'b010, 1'b0, 2'd0, 11'd0, 1'b0};
  localparam res_t PinEmptyReport = '{3'b000, 1'b1, 2'd0, 11'd0, 1'b0};

  localparam int DirCount = 27;
  localparam dir_row_t DirRows [DirCount] = '{
    // after reset: sensor 0 trigger, echo seen during trigger
    '{RowTick,  '0,         '0,       1'b0, 16'd1,    1'b1, PinSensor0},
    '{RowTick,  '0,         '0,       1'b1, 16'd1,    1'b1, PinSensor0},
    // zero trigger length ends the pulse on the next tick
    '{RowWrite, RegTrigger, '0,       1'b0, 16'd0,    1'b0, NoPin},
    '{RowTick,  '0,         '0,       1'b0, 16'd1,    1'b1, PinSensor0},
    // zero listen length: window closes at once, nothing latched
    '{RowWrite, RegListen,  '0,       1'b0, 16'd0,    1'b0, NoPin},
    '{RowTick,  '0,         '0,       1'b0, 16'd1,    1'b1, PinEmptyReport},
    '{RowWrite, RegUnused,  '1,       1'b0, 16'd0,    1'b0, NoPin},
    '{RowWrite, RegTpc,     '0,       1'b0, 16'd0,    1'b0, NoPin},
    '{RowWrite, RegMaxDist, 19'(CmMax), 1'b0, 16'd0,  1'b0, NoPin},
    '{RowWrite, RegListen,  19'd20,   1'b0, 16'd0,    1'b0, NoPin},
    '{RowWrite, RegTrigger, 19'd1,    1'b0, 16'd0,    1'b0, NoPin},
    '{RowTick,  '0,         '0,       1'b0, 16'd1,    1'b1, PinSensor1},
    // two pulses in one window
    '{RowTick,  '0,         '0,       1'b1, 16'd3,    1'b0, NoPin},
    '{RowTick,  '0,         '0,       1'b0, 16'd2,    1'b0, NoPin},
    '{RowTick,  '0,         '0,       1'b1, 16'd4,    1'b0, NoPin},
    '{RowTick,  '0,         '0,       1'b0, 16'd11,   1'b0, NoPin},
    // no idle: last sensor goes straight back to sensor 0
    '{RowWrite, RegIdle,    '0,       1'b0, 16'd0,    1'b0, NoPin},
    '{RowTick,  '0,         '0,       1'b1, 16'd21,   1'b0, NoPin},
    // echo held high through the idle pause
    '{RowWrite, RegIdle,    19'd5,    1'b0, 16'd0,    1'b0, NoPin},
    '{RowTick,  '0,         '0,       1'b0, 16'd63,   1'b0, NoPin},
    '{RowTick,  '0,         '0,       1'b1, 16'd5,    1'b0, NoPin},
    '{RowTick,  '0,         '0,       1'b0, 16'd3,    1'b0, NoPin},
    // long echo in a wide window, then window cut short mid-phase
    '{RowWrite, RegListen,  19'hFFFF, 1'b0, 16'd0,    1'b0, NoPin},
    '{RowTick,  '0,         '0,       1'b1, 16'd40,   1'b0, NoPin},
    '{RowTick,  '0,         '0,       1'b0, 16'd1,    1'b0, NoPin},
    '{RowWrite, RegListen,  19'd1,    1'b0, 16'd0,    1'b0, NoPin},
    '{RowTick,  '0,         '0,       1'b0, 16'd1,    1'b0, NoPin}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  ultrasonic_range_sequencer #(
    .SENSOR_COUNT(SensorCount)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sequencer mirror: registers and measurement state
  cfg_t         m_cfg;
  seq_phase_e   m_phase;
  logic [1:0]   m_sensor;
  logic [18:0]  m_ticks;
  logic [15:0]  m_echo_cnt;
  logic [7:0]   m_sub;
  logic [10:0]  m_run_cm;
  logic [10:0]  m_latch_cm;
  logic         m_echo_prev;

  res_t         range_q [$];
  tick_req_t    tick_plan [$];
  int           fault_count = 0;
  int           cycle_count = 0;
  int           stall_mode = 0;
  int           burst_left = 1;
  int           gap_left = 0;

  function automatic void arm_sensor(logic [1:0] sensor);
    m_phase    = PhTrigger;
    m_sensor   = sensor;
    m_ticks    = '0;
    m_echo_cnt = '0;
    m_sub      = '0;
    m_run_cm   = '0;
    m_latch_cm = '0;
  endfunction

  // Advance the mirror by one tick and return the reading it shows
  function automatic res_t range_of_tick(logic echo);
    res_t       r;
    logic [1:0] sensor;
    bit         last_sensor;
    r = '0;
    sensor = m_sensor;
    last_sensor = (int'(sensor) + 1 >= SensorCount);
    if (m_phase == PhTrigger) r.trigger_lines = 3'b001 << sensor;
    // echo counting and edge detect come before the end-of-phase test
    if (m_phase != PhIdle) begin
      if (echo) begin
        if (m_echo_cnt != '1) m_echo_cnt = m_echo_cnt + 16'd1;
        m_sub = m_sub + 8'd1;
        if (m_sub >= m_cfg.ticks_per_cm || m_sub == 8'd0) begin
          m_sub = '0;
          if (m_run_cm != CmMax) m_run_cm = m_run_cm + 11'd1;
        end
      end
      if (m_echo_prev && !echo) m_latch_cm = m_run_cm;
    end
    m_echo_prev = echo;
    m_ticks = m_ticks + 19'd1;
    case (m_phase)
      PhTrigger: begin
        if (m_ticks >= 19'(m_cfg.trigger_ticks)) begin
          m_phase = PhListen;
          m_ticks = '0;
        end
      end
      PhListen: begin
        if (m_ticks >= 19'(m_cfg.listen_ticks)) begin
          r.report_valid  = 1'b1;
          r.sensor_number = sensor;
          r.distance_cm   = (m_latch_cm != '0 && m_latch_cm < m_cfg.max_distance) ?
                            m_latch_cm : '0;
          r.last_of_round = last_sensor;
          if (!last_sensor) arm_sensor(sensor + 2'd1);
          else if (m_cfg.idle_ticks == '0) arm_sensor('0);
          else begin
            m_phase = PhIdle;
            m_ticks = '0;
          end
        end
      end
      default: begin
        if (m_ticks >= m_cfg.idle_ticks) arm_sensor('0);
      end
    endcase
    return r;
  endfunction

  // Random register value: mostly small, sometimes an extreme, junk above the field
  function automatic logic [CfgDataW-1:0] pick_reg(int ext, int width, int lo, int hi,
                                                   int floor_v, int ceil_v);
    int                  roll;
    logic [CfgDataW-1:0] v;
    roll = $urandom_range(0, 9);
    if (ext == 1 || (ext == 0 && roll == 0)) v = CfgDataW'(floor_v);
    else if (ext == 2 || roll == 1) v = CfgDataW'(ceil_v);
    else v = CfgDataW'($urandom_range(lo, hi));
    if ($urandom_range(0, 3) == 0) v = v | (CfgDataW'($urandom) << width);
    return v;
  endfunction

  // Register write, only once every reading has come back
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    while (range_q.size() != 0) @(posedge clk_i);
    repeat (DrainPad) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegTrigger: m_cfg.trigger_ticks = data[TrigW-1:0];
      RegListen:  m_cfg.listen_ticks  = data[ListenW-1:0];
      RegIdle:    m_cfg.idle_ticks    = data[IdleW-1:0];
      RegTpc:     m_cfg.ticks_per_cm  = data[TpcW-1:0];
      RegMaxDist: m_cfg.max_distance  = data[DistW-1:0];
      default: ;
    endcase
  endtask

  // Send the planned ticks in bursts with gaps; predict on each accepted request
  task automatic play_ticks();
    res_t want;
    bit   took;
    while (tick_plan.size() > 0 || s_axis_tvalid) begin
      @(posedge clk_i);
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        want = range_of_tick(tick_plan[0].echo);
        if (tick_plan[0].pinned) want = tick_plan[0].pin;
        range_q.push_back(want);
        void'(tick_plan.pop_front());
      end
      if (s_axis_tvalid && !took) begin
        // hold the request until taken
      end else if (tick_plan.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, tick_plan[0].echo};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) :
                       $urandom_range(1, 8);
          gap_left = $urandom_range(0, 6);
        end
      end
    end
  endtask

  // Receiver stalls, changing pattern at random; run watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > Limit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= (cycle_count % 4 != 0);
        default: m_axis_tready <= (cycle_count % 8 < 2);
      endcase
    end
  end

  // Compare each taken reading with the oldest prediction
  always @(posedge clk_i) begin : check_range
    res_t want;
    res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[2:0], m_axis_tuser, m_axis_tdata[4:3], m_axis_tdata[15:5],
              m_axis_tlast};
      if (range_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected reading: trig=%b valid=%0d sensor=%0d dist=%0d last=%0d",
                   got.trigger_lines, got.report_valid, got.sensor_number,
                   got.distance_cm, got.last_of_round);
      end else begin
        want = range_q.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= 10)
            $display({"mismatch: want trig=%b valid=%0d sensor=%0d dist=%0d last=%0d, ",
                      "got trig=%b valid=%0d sensor=%0d dist=%0d last=%0d"},
                     want.trigger_lines, want.report_valid, want.sensor_number,
                     want.distance_cm, want.last_of_round,
                     got.trigger_lines, got.report_valid, got.sensor_number,
                     got.distance_cm, got.last_of_round);
        end
      end
    end
  end

  initial begin
    int ext;
    int low_len;
    int high_len;
    m_cfg = '{TrigReset, ListenReset, IdleReset, TpcReset, MaxDistReset};
    arm_sensor('0);
    m_echo_prev = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: tick rows queue up, write rows drain first
    for (int i = 0; i < DirCount; i++) begin
      if (DirRows[i].kind == RowWrite) begin
        play_ticks();
        write_reg(DirRows[i].idx, DirRows[i].data);
      end else begin
        repeat (DirRows[i].reps)
          tick_plan.push_back('{DirRows[i].echo, DirRows[i].pinned, DirRows[i].pin});
      end
    end
    play_ticks();

    // Random phases: new settings each time, then echo pulse trains with some noise
    for (int p = 0; p < RandPhases; p++) begin
      ext = (p == 2) ? 2 : (p == 5) ? 1 : 0;
      write_reg(RegTrigger, pick_reg(ext, TrigW,   1, 6,  0, 1023));
      write_reg(RegListen,  pick_reg(ext, ListenW, 3, 40, 0, 65535));
      write_reg(RegIdle,    pick_reg(ext, IdleW,   1, 20, 0, 524287));
      write_reg(RegTpc,     pick_reg(ext, TpcW,    1, 6,  0, 255));
      write_reg(RegMaxDist, pick_reg(ext, DistW,   2, 40, 1, 2047));
      write_reg(RegUnused + CfgIdxW'($urandom_range(0, 2)), CfgDataW'($urandom));
      while (tick_plan.size() < PhaseTicks) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 8))
            tick_plan.push_back('{1'($urandom_range(0, 1)), 1'b0, NoPin});
        end else begin
          low_len  = $urandom_range(0, 15);
          high_len = $urandom_range(1, 30);
          repeat (low_len) tick_plan.push_back('{1'b0, 1'b0, NoPin});
          repeat (high_len) tick_plan.push_back('{1'b1, 1'b0, NoPin});
        end
      end
      play_ticks();
    end

    // Drain, then keep watching for stray readings
    while (range_q.size() != 0) @(posedge clk_i);
    repeat (DrainPad * 4) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
